### hdl/mtxq_pkg.sv
// Shared constants, outcome codes and controller/datapath interface types for the mutex unit.
`default_nettype none

package mtxq_pkg;

  localparam int MUTEXES = 8;
  localparam int THREADS = 8;

  // Fixed field widths
  localparam int FUNC_W    = 1;
  localparam int THREAD_W  = 3;
  localparam int MUTEX_W   = 3;
  localparam int OUTCOME_W = 3;
  localparam int MCOUNT_W  = 4;

  // Derived storage widths
  localparam int MUTEX_IDX_W = (MUTEXES > 1) ? $clog2(MUTEXES) : 1;
  localparam int SLOT_W      = $clog2(THREADS);
  localparam int CNT_W       = $clog2(THREADS + 1);
  localparam int WQ_ADDR_W   = MUTEX_IDX_W + SLOT_W;
  localparam int WQ_DEPTH    = 2 ** WQ_ADDR_W;

  localparam logic [FUNC_W-1:0] FUNC_ACQUIRE = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 1'b1;

  localparam logic [OUTCOME_W-1:0] OUT_ACQUIRED  = 3'd0;
  localparam logic [OUTCOME_W-1:0] OUT_BLOCKED   = 3'd1;
  localparam logic [OUTCOME_W-1:0] OUT_DUPLICATE = 3'd2;
  localparam logic [OUTCOME_W-1:0] OUT_FULL      = 3'd3;
  localparam logic [OUTCOME_W-1:0] OUT_FREED     = 3'd4;
  localparam logic [OUTCOME_W-1:0] OUT_HANDOVER  = 3'd5;
  localparam logic [OUTCOME_W-1:0] OUT_NOT_OWNER = 3'd6;
  localparam logic [OUTCOME_W-1:0] OUT_BAD       = 3'd7;

  typedef struct packed {
    logic                 load;       // capture request word
    logic                 take;       // grant mutex to requester
    logic                 scan_start; // reset duplicate search
    logic                 scan_step;  // advance duplicate search
    logic                 append;     // enqueue requester
    logic                 free;       // mark mutex free
    logic                 rd_head;    // read head of queue
    logic                 handover;   // pass mutex to head waiter
    logic                 set_res;    // latch result
    logic [OUTCOME_W-1:0] res_code;
    logic                 push;       // move result to output register
  } dp_cmd_t;

  typedef struct packed {
    logic bad;
    logic is_release;
    logic acq_ok;
    logic owner_match;
    logic q_empty;
    logic q_full;
    logic hit;
    logic scan_done;
    logic slot_free;
  } dp_stat_t;

endpackage

`default_nettype wire

### hdl/mtxq_ctrl.sv
// Sequencing state machine of the mutex unit.
`default_nettype none

module mtxq_ctrl
  import mtxq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_HEAD   = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.bad) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = OUT_BAD;
          state_next   = ST_DONE;
        end else if (!stat.is_release) begin
          if (stat.acq_ok) begin
            cmd.take     = 1'b1;
            cmd.set_res  = 1'b1;
            cmd.res_code = OUT_ACQUIRED;
            state_next   = ST_DONE;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = ST_SCAN;
          end
        end else if (!stat.owner_match) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = OUT_NOT_OWNER;
          state_next   = ST_DONE;
        end else if (stat.q_empty) begin
          cmd.free     = 1'b1;
          cmd.set_res  = 1'b1;
          cmd.res_code = OUT_FREED;
          state_next   = ST_DONE;
        end else begin
          cmd.rd_head = 1'b1;
          state_next  = ST_HEAD;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.hit) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = OUT_DUPLICATE;
          state_next   = ST_DONE;
        end else if (stat.scan_done) begin
          cmd.set_res = 1'b1;
          if (stat.q_full) begin
            cmd.res_code = OUT_FULL;
          end else begin
            cmd.append   = 1'b1;
            cmd.res_code = OUT_BLOCKED;
          end
          state_next = ST_DONE;
        end
      end
      ST_HEAD: begin
        cmd.handover = 1'b1;
        cmd.set_res  = 1'b1;
        cmd.res_code = OUT_HANDOVER;
        state_next   = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register can take the word
        if (stat.slot_free) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/mtxq_dp.sv
// Datapath of the mutex unit: per-mutex state, wait queue memory and output register.
`default_nettype none

module mtxq_dp
  import mtxq_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [MCOUNT_W-1:0]  cfg_wr_data,
  input  wire logic [FUNC_W-1:0]    func,
  input  wire logic [THREAD_W-1:0]  thread,
  input  wire logic [MUTEX_W-1:0]   mutex,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output logic [OUTCOME_W-1:0]      outcome,
  output logic [THREAD_W-1:0]       woken_thread,
  output logic                      woken_valid,
  input  wire dp_cmd_t              cmd,
  output dp_stat_t                  stat
);

  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                 input logic [SLOT_W-1:0] b);
    logic [SLOT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (SLOT_W + 1)'(THREADS)) begin
      s = s - (SLOT_W + 1)'(THREADS);
    end
    return s[SLOT_W-1:0];
  endfunction

  logic [MCOUNT_W-1:0] mutex_count;

  logic [FUNC_W-1:0]   req_func;
  logic [THREAD_W-1:0] req_thread;
  logic [MUTEX_W-1:0]  req_mutex;

  logic                is_free      [MUTEXES];
  logic [THREAD_W-1:0] owner_thread [MUTEXES];
  logic                owner_valid  [MUTEXES];
  logic [CNT_W-1:0]    wait_count   [MUTEXES];
  logic [SLOT_W-1:0]   head         [MUTEXES];

  logic [THREAD_W-1:0] wq_mem [WQ_DEPTH];
  logic [THREAD_W-1:0] rdata;
  logic [WQ_ADDR_W-1:0] raddr;
  logic [WQ_ADDR_W-1:0] waddr;

  logic [CNT_W-1:0] scan_idx;
  logic             scan_pend;
  logic             scan_issue;

  logic [OUTCOME_W-1:0] res_code;
  logic [THREAD_W-1:0]  res_woken;
  logic                 res_wvalid;

  logic [MUTEX_IDX_W-1:0] m;
  logic [CNT_W-1:0]       cnt;
  logic [SLOT_W-1:0]      hd;

  assign m   = MUTEX_IDX_W'(req_mutex);
  assign cnt = wait_count[m];
  assign hd  = head[m];

  assign scan_issue = cmd.scan_step && (scan_idx < cnt);
  assign raddr = cmd.rd_head ? {m, hd} : {m, slot_add(hd, scan_idx[SLOT_W-1:0])};
  assign waddr = {m, slot_add(hd, cnt[SLOT_W-1:0])};

  always_comb begin
    stat.bad = ({1'b0, req_mutex} >= mutex_count) ||
               (32'(req_mutex) >= MUTEXES) || (32'(req_thread) >= THREADS);
    stat.is_release  = (req_func == FUNC_RELEASE);
    stat.owner_match = owner_valid[m] && (owner_thread[m] == req_thread);
    stat.acq_ok      = is_free[m] || stat.owner_match;
    stat.q_empty     = (cnt == '0);
    stat.q_full      = (cnt == CNT_W'(THREADS));
    stat.hit         = scan_pend && (rdata == req_thread);
    stat.scan_done   = !scan_pend && (scan_idx >= cnt);
    stat.slot_free   = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mutex_count <= '0;
    end else if (cfg_wr_en) begin
      mutex_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_func   <= func;
      req_thread <= thread;
      req_mutex  <= mutex;
    end
  end

  // wait queue: one circular buffer per mutex
  always_ff @(posedge clk) begin
    rdata <= wq_mem[raddr];
    if (cmd.append) begin
      wq_mem[waddr] <= req_thread;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx  <= '0;
      scan_pend <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_idx  <= '0;
      scan_pend <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_pend <= scan_issue;
      if (scan_issue) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MUTEXES; i++) begin
        is_free[i]      <= 1'b1;
        owner_thread[i] <= '0;
        owner_valid[i]  <= 1'b0;
        wait_count[i]   <= '0;
        head[i]         <= '0;
      end
    end else begin
      if (cmd.take) begin
        owner_thread[m] <= req_thread;
        owner_valid[m]  <= 1'b1;
        is_free[m]      <= 1'b0;
      end
      if (cmd.free) begin
        is_free[m] <= 1'b1;
      end
      if (cmd.append) begin
        wait_count[m] <= cnt + 1'b1;
      end
      if (cmd.handover) begin
        owner_thread[m] <= rdata;
        owner_valid[m]  <= 1'b1;
        is_free[m]      <= 1'b0;
        head[m]         <= slot_add(hd, SLOT_W'(1));
        wait_count[m]   <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_code   <= cmd.res_code;
      res_woken  <= cmd.handover ? rdata : '0;
      res_wvalid <= cmd.handover;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      outcome      <= res_code;
      woken_thread <= res_woken;
      woken_valid  <= res_wvalid;
    end
  end

endmodule

`default_nettype wire

### hdl/mutex_unit_with_fifo_wait_queues_core.sv
// Top level of the mutex unit with per-mutex FIFO wait queues.
// Usage:
//   Input channel (in_valid/in_stall) carries one request word: func
//   (acquire or release), thread and mutex. Output channel
//   (out_valid/out_stall) returns one result word per request: outcome,
//   woken_thread and woken_valid.
//   cfg_wr_en/cfg_wr_data write mutex_count, the number of usable mutexes;
//   write it only while no request is in flight.
// Timing:
//   One request is handled at a time. Grants, frees, rejects and refusals
//   are decided directly; a handover first reads the queue head, and a
//   blocked acquire first searches its queue for a duplicate, which reads
//   the wait queue one entry per cycle through its single read port. A new
//   request is taken the cycle after a result loads.
//   in_stall stays high from acceptance until the result is placed in the
//   output register.
// Reset: every mutex free with no owner, all queues empty, mutex_count 0.
// A stalled output word holds; the block finishes the next request and
// waits with it until the output register frees.
`default_nettype none

module mutex_unit_with_fifo_wait_queues_core
  import mtxq_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [MCOUNT_W-1:0]  cfg_wr_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [FUNC_W-1:0]    func,
  input  wire logic [THREAD_W-1:0]  thread,
  input  wire logic [MUTEX_W-1:0]   mutex,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [OUTCOME_W-1:0]      outcome,
  output logic [THREAD_W-1:0]       woken_thread,
  output logic                      woken_valid
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mtxq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mtxq_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .func         (func),
    .thread       (thread),
    .mutex        (mutex),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .outcome      (outcome),
    .woken_thread (woken_thread),
    .woken_valid  (woken_valid),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

`default_nettype wire

### hdl/mtxq_checker.sv
// Port-level checker for the mutex unit, bound to the top level.
`default_nettype none

module mtxq_checker
  import mtxq_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [OUTCOME_W-1:0] outcome,
  input wire logic [THREAD_W-1:0]  woken_thread,
  input wire logic                 woken_valid
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(outcome) &&
      $stable(woken_thread) && $stable(woken_valid))
    else $error("stalled result word changed");

  a_woken_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (woken_valid == (outcome == OUT_HANDOVER)))
    else $error("woken_valid does not match handover outcome");

  a_woken_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !woken_valid |-> woken_thread == '0)
    else $error("woken_thread set without handover");

  // one request at a time: busy after taking a word
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one in progress");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word present after reset");

endmodule

bind mutex_unit_with_fifo_wait_queues_core mtxq_checker u_mtxq_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .outcome      (outcome),
  .woken_thread (woken_thread),
  .woken_valid  (woken_valid)
);

`default_nettype wire

### tb/mutex_unit_with_fifo_wait_queues_core_tb.sv
// Self-checking testbench for the mutex unit: predicts every result word and checks it on output.
`timescale 1ns / 100ps

module mutex_unit_with_fifo_wait_queues_core_tb;
  import mtxq_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 24;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic [THREAD_W-1:0]  woken;
    logic                 woken_valid;
  } lock_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [MCOUNT_W-1:0] cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [FUNC_W-1:0]   func = FUNC_ACQUIRE;
  logic [THREAD_W-1:0] thread = '0;
  logic [MUTEX_W-1:0]  mutex = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [OUTCOME_W-1:0] outcome;
  logic [THREAD_W-1:0] woken_thread;
  logic                woken_valid;

  // Predicted lock state
  bit                  mx_free [MUTEXES];
  bit                  mx_owned [MUTEXES];
  logic [THREAD_W-1:0] mx_owner [MUTEXES];
  logic [THREAD_W-1:0] mx_queue [MUTEXES][THREADS];
  int                  mx_waiting [MUTEXES];
  logic [MCOUNT_W-1:0] live_count;

  lock_result_t pending_results[$];
  int  fail_count = 0;
  int  sent_count = 0;
  int  cycle_count = 0;
  int  outcome_seen [8];
  bit  idle_on = 1'b1;
  int  hold_request = 0;
  int  hold_left = 0;
  int  stall_left = 0;

  mutex_unit_with_fifo_wait_queues_core uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .thread       (thread),
    .mutex        (mutex),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .outcome      (outcome),
    .woken_thread (woken_thread),
    .woken_valid  (woken_valid)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
             pending_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void clear_locks();
    int i;
    for (i = 0; i < MUTEXES; i++) begin
      mx_free[i] = 1'b1;
      mx_owned[i] = 1'b0;
      mx_owner[i] = '0;
      mx_waiting[i] = 0;
    end
    live_count = '0;
  endfunction

  function automatic lock_result_t predict_lock(logic [FUNC_W-1:0] f, logic [THREAD_W-1:0] t,
                                                logic [MUTEX_W-1:0] m);
    lock_result_t r;
    bit dup;
    int i;
    r = '0;
    dup = 1'b0;
    if (m >= live_count || m >= MUTEXES || t >= THREADS) begin
      r.outcome = OUT_BAD;
    end else if (f == FUNC_ACQUIRE) begin
      if (mx_free[m] || (mx_owned[m] && mx_owner[m] == t)) begin
        mx_owner[m] = t;
        mx_owned[m] = 1'b1;
        mx_free[m] = 1'b0;
        r.outcome = OUT_ACQUIRED;
      end else begin
        for (i = 0; i < mx_waiting[m]; i++)
          if (mx_queue[m][i] == t) dup = 1'b1;
        if (dup) begin
          r.outcome = OUT_DUPLICATE;
        end else if (mx_waiting[m] >= THREADS) begin
          r.outcome = OUT_FULL;
        end else begin
          mx_queue[m][mx_waiting[m]] = t;
          mx_waiting[m]++;
          r.outcome = OUT_BLOCKED;
        end
      end
    end else begin
      if (!(mx_owned[m] && mx_owner[m] == t)) begin
        r.outcome = OUT_NOT_OWNER;
      end else if (mx_waiting[m] == 0) begin
        // last owner stays on record
        mx_free[m] = 1'b1;
        r.outcome = OUT_FREED;
      end else begin
        r.woken = mx_queue[m][0];
        r.woken_valid = 1'b1;
        mx_owner[m] = r.woken;
        mx_owned[m] = 1'b1;
        mx_free[m] = 1'b0;
        for (i = 0; i + 1 < mx_waiting[m]; i++)
          mx_queue[m][i] = mx_queue[m][i + 1];
        mx_waiting[m]--;
        r.outcome = OUT_HANDOVER;
      end
    end
    return r;
  endfunction

  task automatic send_word(logic [FUNC_W-1:0] f, logic [THREAD_W-1:0] t,
                           logic [MUTEX_W-1:0] m);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    func <= f;
    thread <= t;
    mutex <= m;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_lock(f, t, m));
    sent_count++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(logic [MCOUNT_W-1:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    live_count = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly sensible traffic: releases usually come from the owner
  task automatic send_random_word(bit focus);
    logic [FUNC_W-1:0]   f;
    logic [THREAD_W-1:0] t;
    logic [MUTEX_W-1:0]  m;
    if ($urandom_range(0, 99) < 8) begin
      f = FUNC_W'($urandom);
      t = THREAD_W'($urandom);
      m = MUTEX_W'($urandom);
    end else begin
      m = (focus && $urandom_range(0, 99) < 60) ? MUTEX_W'($urandom_range(0, 1)) :
                                                  MUTEX_W'($urandom_range(0, 7));
      t = THREAD_W'($urandom);
      if ($urandom_range(0, 99) < 55) begin
        f = FUNC_ACQUIRE;
      end else begin
        f = FUNC_RELEASE;
        if (mx_owned[m] && $urandom_range(0, 99) < 75) t = mx_owner[m];
      end
    end
    send_word(f, t, m);
  endtask

  task automatic test_directed();
    int i;
    // nothing created yet
    send_word(FUNC_ACQUIRE, 3'd0, 3'd0);
    stop_sending();
    wait_drained();
    write_count(4'd8);
    send_word(FUNC_RELEASE, 3'd0, 3'd0);
    send_word(FUNC_ACQUIRE, 3'd0, 3'd0);
    send_word(FUNC_ACQUIRE, 3'd0, 3'd0);
    send_word(FUNC_ACQUIRE, 3'd3, 3'd0);
    send_word(FUNC_ACQUIRE, 3'd3, 3'd0);
    send_word(FUNC_RELEASE, 3'd5, 3'd0);
    send_word(FUNC_RELEASE, 3'd0, 3'd0);
    send_word(FUNC_RELEASE, 3'd3, 3'd0);
    send_word(FUNC_RELEASE, 3'd3, 3'd0);
    // the owner never waits, so seven waiters is the deepest queue
    send_word(FUNC_ACQUIRE, 3'd7, 3'd7);
    for (i = 0; i < 7; i++) send_word(FUNC_ACQUIRE, i[2:0], 3'd7);
    send_word(FUNC_ACQUIRE, 3'd7, 3'd7);
    send_word(FUNC_RELEASE, 3'd7, 3'd7);
    send_word(FUNC_RELEASE, 3'd0, 3'd7);
    stop_sending();
    wait_drained();
  endtask

  task automatic test_count_sweep();
    logic [MCOUNT_W-1:0] counts [6];
    int i;
    int k;
    counts = '{4'd3, 4'd1, 4'd0, 4'd8, 4'd5, 4'd7};
    for (i = 0; i < 6; i++) begin
      write_count(counts[i]);
      // hit the first index past the limit directly (for a count of 8 the index wraps to 0)
      send_word(FUNC_ACQUIRE, THREAD_W'($urandom), counts[i][MUTEX_W-1:0]);
      for (k = 0; k < 40; k++) send_random_word(1'b0);
      stop_sending();
      wait_drained();
    end
  endtask

  task automatic test_random(int n);
    int k;
    write_count(4'd8);
    for (k = 0; k < n; k++) begin
      if (k % 100 == 0) idle_on = ((k / 100) % 3 != 1);
      send_random_word(1'b1);
    end
    stop_sending();
    idle_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_backpressure();
    int k;
    idle_on = 1'b0;
    @(posedge clk);
    hold_request = 400;
    for (k = 0; k < 30; k++) send_random_word(1'b1);
    stop_sending();
    wait_drained();
    idle_on = 1'b1;
  endtask

  // Receiver: random stalls, plus a counted hold-off on request
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    lock_result_t exp_word;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none expected: outcome %0d", $realtime, outcome);
        fail_count++;
      end else begin
        exp_word = pending_results.pop_front();
        outcome_seen[outcome]++;
        if (outcome !== exp_word.outcome) begin
          $display("%0t: outcome expected %0d got %0d", $realtime, exp_word.outcome, outcome);
          fail_count++;
        end
        if (woken_thread !== exp_word.woken) begin
          $display("%0t: woken_thread expected %0d got %0d", $realtime, exp_word.woken,
                   woken_thread);
          fail_count++;
        end
        if (woken_valid !== exp_word.woken_valid) begin
          $display("%0t: woken_valid expected %0d got %0d", $realtime, exp_word.woken_valid,
                   woken_valid);
          fail_count++;
        end
      end
    end
  end

  initial begin
    clear_locks();
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_count_sweep();
    test_random(1400);
    test_backpressure();
    if (pending_results.size() != 0) begin
      $display("%0t: %0d result words never arrived", $realtime, pending_results.size());
      fail_count++;
    end
    $display("Sent %0d request words in %0d cycles; mutex_count swept 0, 1, 3, 5, 7, 8; %s",
             sent_count, cycle_count, "one long output hold-off filled the unit.");
    $display("Outcomes: acq %0d, blocked %0d, dup %0d, full %0d, freed %0d, %s %0d, %s %0d, bad %0d",
             outcome_seen[OUT_ACQUIRED], outcome_seen[OUT_BLOCKED], outcome_seen[OUT_DUPLICATE],
             outcome_seen[OUT_FULL], outcome_seen[OUT_FREED], "handover",
             outcome_seen[OUT_HANDOVER], "not owner", outcome_seen[OUT_NOT_OWNER],
             outcome_seen[OUT_BAD]);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
